/* src/stbg_pkg.sv */
`default_nettype none
package stbg_pkg;

    localparam int SAMPLE_RATE_HZ_DEF   = 44100;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int SYMBOL_COUNT_DEF     = 32;

    localparam int FRAME_RESET = 3845;

    localparam logic [1:0] REG_BAND  = 2'd0;
    localparam logic [1:0] REG_FRAME = 2'd1;
    localparam logic [1:0] REG_CHAN  = 2'd2;

    localparam logic [31:0] Q30_ONE = 32'd1073741824;
    localparam logic [31:0] PC1 = 32'd1686629713;
    localparam logic [31:0] PC3 = 32'd693598668;
    localparam logic [31:0] PC5 = 32'd85569306;
    localparam logic [31:0] PC7 = 32'd5026995;
    localparam logic [31:0] PC9 = 32'd172272;

    function automatic logic [13:0] low_band_hz(input logic [4:0] k);
        logic [13:0] r;
        begin
            unique case (k)
                5'd0: r = 14'd1760;  5'd1: r = 14'd1864;  5'd2: r = 14'd1975;
                5'd3: r = 14'd2093;  5'd4: r = 14'd2217;  5'd5: r = 14'd2349;
                5'd6: r = 14'd2489;  5'd7: r = 14'd2637;  5'd8: r = 14'd2793;
                5'd9: r = 14'd2959;  5'd10: r = 14'd3135; 5'd11: r = 14'd3322;
                5'd12: r = 14'd3520; 5'd13: r = 14'd3729; 5'd14: r = 14'd3951;
                5'd15: r = 14'd4186; 5'd16: r = 14'd4434; 5'd17: r = 14'd4698;
                5'd18: r = 14'd4978; 5'd19: r = 14'd5274; 5'd20: r = 14'd5587;
                5'd21: r = 14'd5919; 5'd22: r = 14'd6271; 5'd23: r = 14'd6644;
                5'd24: r = 14'd7040; 5'd25: r = 14'd7458; 5'd26: r = 14'd7902;
                5'd27: r = 14'd8372; 5'd28: r = 14'd8869; 5'd29: r = 14'd9397;
                5'd30: r = 14'd9956; default: r = 14'd10548;
            endcase
            return r;
        end
    endfunction

    typedef struct packed {
        logic        start;
        logic        bad;
        logic [15:0] len;
        logic [15:0] n;
        logic [31:0] phase;
    } stbg_req_t;

endpackage
`default_nettype wire

/* src/stbg_unit.sv */
`default_nettype none
// shared sequencer: window isqrt (bit pairs), window divide (restoring),
// sine polynomial (horner on one 32x32 multiplier) and final scaling
module stbg_unit #(
    parameter int SINE_TABLE_DEPTH = stbg_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stbg_pkg::stbg_req_t req,
    output logic                   done,
    output logic signed [14:0]     result
);
    import stbg_pkg::*;

    localparam int AW = $clog2(SINE_TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_SQRT, S_LOAD, S_DIV, S_POLY, S_SCALE, S_DONE
    } state_t;

    state_t      state_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [31:0] root_reg;
    logic [33:0] rem_reg;
    logic [31:0] quo_reg;
    logic [15:0] len_reg;
    logic        bad_reg;
    logic [31:0] phase_reg;
    logic [30:0] t_reg;
    logic [31:0] t2_reg;
    logic [31:0] p_reg;
    logic [31:0] mult_a;
    logic [31:0] mult_b;
    logic [63:0] prod;
    logic [33:0] trial;
    logic [32:0] dtrial;
    logic [31:0] q;
    logic        neg_reg;
    logic [15:0] sine_mag_reg;
    logic signed [14:0] result_reg;
    logic [31:0] m;
    logic [31:0] vol_c;
    logic [31:0] coef;
    logic [47:0] smp_prod;
    logic [31:0] smag;

    assign q = {phase_reg[31 -: AW], {(32 - AW){1'b0}}};
    assign m = (req.n < req.len) ? 32'(req.n) * 32'(req.len - req.n) : 32'd0;
    assign prod = 64'(mult_a) * 64'(mult_b);
    // restoring sqrt: one result bit per cycle
    assign trial = {rem_reg[31:0], rad_reg[63:62]} - {root_reg, 2'b01};
    assign dtrial = {rem_reg[31:0], quo_reg[31]} - {17'd0, len_reg};
    assign vol_c = quo_reg;

    always_comb
    begin
        unique case (cnt_reg[2:0])
            3'd0: coef = PC7;
            3'd1: coef = PC5;
            3'd2: coef = PC3;
            default: coef = PC1;
        endcase
        mult_a = p_reg;
        mult_b = t2_reg;
        if (cnt_reg == 5'd31)
        begin
            mult_a = {1'b0, t_reg};
            mult_b = {1'b0, t_reg};
        end
        else if (cnt_reg[2:0] == 3'd4)
        begin
            mult_b = {1'b0, t_reg};
        end
    end

    assign smp_prod = 48'(sine_mag_reg) * 48'(root_reg[15:0]) + 48'd16384;
    assign smag = smp_prod[46:15];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            rad_reg      <= '0;
            root_reg     <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            len_reg      <= '0;
            bad_reg      <= 1'b0;
            phase_reg    <= '0;
            t_reg        <= '0;
            t2_reg       <= '0;
            p_reg        <= '0;
            neg_reg      <= 1'b0;
            sine_mag_reg <= '0;
            result_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= S_SQRT;
                        cnt_reg   <= '0;
                        rad_reg   <= {2'b00, m, 30'd0};
                        root_reg  <= '0;
                        rem_reg   <= '0;
                        len_reg   <= (req.len == 16'd0) ? 16'd1 : req.len;
                        bad_reg   <= req.bad;
                        phase_reg <= req.phase;
                    end
                end
                S_SQRT:
                begin
                    rad_reg <= {rad_reg[61:0], 2'b00};
                    if (!trial[33])
                    begin
                        rem_reg  <= trial;
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= {rem_reg[31:0], rad_reg[63:62]};
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_LOAD;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                    end
                end
                S_LOAD:
                begin
                    // load dividend sqrt + len/2
                    quo_reg   <= root_reg + 32'(len_reg >> 1);
                    rem_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!dtrial[32])
                        rem_reg <= {1'b0, dtrial};
                    else
                        rem_reg <= {2'b00, rem_reg[30:0], quo_reg[31]};
                    quo_reg <= {quo_reg[30:0], ~dtrial[32]};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_POLY;
                        cnt_reg   <= 5'd31;
                        t_reg <= q[30] ? 31'(Q30_ONE - {2'b00, q[29:0]}) : {1'b0, q[29:0]};
                        neg_reg <= q[31];
                        p_reg <= PC9;
                    end
                end
                S_POLY:
                begin
                    if (cnt_reg == 5'd31)
                    begin
                        t2_reg  <= prod[61:30];
                        cnt_reg <= '0;
                    end
                    else if (cnt_reg[2:0] == 3'd4)
                    begin
                        sine_mag_reg <= (prod[61:30] > Q30_ONE) ? 16'h8000 :
                                        16'((prod[61:30] + 32'd16384) >> 15);
                        root_reg  <= vol_c;
                        state_reg <= S_SCALE;
                    end
                    else
                    begin
                        p_reg   <= coef - prod[61:30];
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_SCALE:
                begin
                    if (bad_reg)
                        result_reg <= '0;
                    else if (neg_reg && sine_mag_reg != 16'd0)
                        result_reg <= 15'(-$signed({1'b0, smag}));
                    else
                        result_reg <= (smag > 32'd16383) ? 15'sd16383 : 15'(smag);
                    state_reg <= S_DONE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = (state_reg == S_DONE);
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == S_IDLE) else $error("start while busy");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_scale_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCALE |=> done) else $error("scale not done");
`endif
endmodule
`default_nettype wire

/* src/symbol_tone_burst_generator.sv */
`default_nettype none
// symbol tone burst generator: one input word is one audio sample tick.
// s_axis tdata carries the character; tuser carries the last-symbol mark.
// the character and mark are latched on the first tick of each frame.
// for each tick the block emits one word (mono) or two (stereo, same sample)
// on m_axis; tlast marks the final word of the tick.
// config: write cfg_we with cfg_addr 0 band, 1 frame length, 2 channel count,
// only while idle.
// each tick runs through the shared sqrt/divide/polynomial sequencer (sqrt, load,
// divide, polynomial and scale states); its result is then registered for m_axis.
// a new tick is taken only once every word of the last tick has been accepted;
// a stalled receiver delays the next tick.
// s_axis_tready is low while a tick is in work or its words wait.
// a stalled receiver holds the output word; no tick is taken meanwhile.
// reset clears phase, sample index, step and flags; config returns to
// band 0, frame 3845, stereo.
module symbol_tone_burst_generator #(
    parameter int SAMPLE_RATE_HZ   = stbg_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int SINE_TABLE_DEPTH = stbg_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int SYMBOL_COUNT     = stbg_pkg::SYMBOL_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // symbol_char
    input  wire logic        s_axis_tuser,   // last_symbol
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // sample[14:0], pad
    output logic [7:0]       m_axis_tuser,   // channel, symbol_end, message_end, bad_symbol, pad
    output logic             m_axis_tlast    // last_of_tick
);
    import stbg_pkg::*;

    typedef enum logic [1:0] {T_IDLE, T_BUSY, T_OUT} tstate_t;

    logic        band_reg;
    logic [15:0] frame_reg;
    logic [1:0]  chan_cnt_reg;
    logic [31:0] phase_reg;
    logic [15:0] idx_reg;
    logic [31:0] step_reg;
    logic        inv_reg;
    logic        fin_reg;
    tstate_t     st_reg;
    logic        ch_reg;
    logic        stereo_reg;
    logic        send_reg;
    logic        mend_reg;
    logic        bad_reg;
    logic signed [14:0] smp_reg;
    logic [31:0] phase_work_reg;
    logic [15:0] n_work_reg;
    logic        bad_work_reg;

    stbg_req_t   req;
    logic        u_done;
    logic signed [14:0] u_res;
    logic [15:0] len;
    logic        acc;
    logic        first;
    logic [7:0]  ch;
    logic [4:0]  k;
    logic        ok;
    logic [31:0] new_step;
    logic        cur_inv;
    logic [31:0] cur_step;
    logic        sym_end;

    // step = round(f*2^32/fs), f <= 19984 fits 15 bits; table of 32 per band
    function automatic logic [31:0] step_of(input logic [14:0] f);
        logic [63:0] num;
        begin
            num = ({49'd0, f} << 32) + 64'(SAMPLE_RATE_HZ / 2);
            return 32'(num / 64'(SAMPLE_RATE_HZ));
        end
    endfunction

    logic [31:0] step_tab_low  [32];
    logic [31:0] step_tab_high [32];
    for (genvar g = 0; g < 32; g++)
    begin : g_tab
        assign step_tab_low[g]  = step_of({1'b0, low_band_hz(5'(g))});
        assign step_tab_high[g] = step_of(15'(18000 + 64 * g));
    end

    assign len   = (frame_reg == 16'd0) ? 16'd1 : frame_reg;
    assign acc   = s_axis_tvalid && s_axis_tready;
    assign first = (idx_reg == 16'd0);
    assign ch    = s_axis_tdata;
    always_comb
    begin
        k  = '0;
        ok = 1'b0;
        if (ch >= 8'd48 && ch <= 8'd57)
        begin
            k = 5'(ch - 8'd48); ok = 1'b1;
        end
        else if (ch >= 8'd97 && ch <= 8'd118)
        begin
            k = 5'(ch - 8'd87); ok = 1'b1;
        end
        if (ok && 32'(k) >= 32'(SYMBOL_COUNT))
            ok = 1'b0;
        new_step = ok ? (band_reg ? step_tab_high[k] : step_tab_low[k]) : 32'd0;
        cur_inv  = first ? !ok : inv_reg;
        cur_step = first ? new_step : step_reg;
    end

    assign sym_end = (17'(n_work_reg) + 17'd1 >= 17'(len));

    assign req.start = acc;
    assign req.bad   = cur_inv;
    assign req.len   = frame_reg;
    assign req.n     = idx_reg;
    assign req.phase = phase_reg;

    stbg_unit #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_unit (
        .clk(clk), .rst_n(rst_n), .req(req), .done(u_done), .result(u_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg       <= 1'b0;
            frame_reg      <= 16'(FRAME_RESET);
            chan_cnt_reg   <= 2'd2;
            phase_reg      <= '0;
            idx_reg        <= '0;
            step_reg       <= '0;
            inv_reg        <= 1'b0;
            fin_reg        <= 1'b0;
            st_reg         <= T_IDLE;
            ch_reg         <= 1'b0;
            stereo_reg     <= 1'b0;
            send_reg       <= 1'b0;
            mend_reg       <= 1'b0;
            bad_reg        <= 1'b0;
            smp_reg        <= '0;
            phase_work_reg <= '0;
            n_work_reg     <= '0;
            bad_work_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_BAND:  band_reg     <= cfg_wdata[0];
                    REG_FRAME: frame_reg    <= cfg_wdata;
                    REG_CHAN:  chan_cnt_reg <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
            unique case (st_reg)
                T_IDLE:
                begin
                    if (acc)
                    begin
                        inv_reg  <= cur_inv;
                        step_reg <= cur_step;
                        if (first)
                            fin_reg <= s_axis_tuser;
                        n_work_reg   <= idx_reg;
                        bad_work_reg <= cur_inv;
                        phase_work_reg <= phase_reg + cur_step;
                        st_reg <= T_BUSY;
                    end
                end
                T_BUSY:
                begin
                    if (u_done)
                    begin
                        smp_reg    <= u_res;
                        bad_reg    <= bad_work_reg;
                        send_reg   <= sym_end;
                        mend_reg   <= sym_end && fin_reg;
                        stereo_reg <= (chan_cnt_reg == 2'd2);
                        ch_reg     <= 1'b0;
                        idx_reg    <= sym_end ? 16'd0 : n_work_reg + 16'd1;
                        phase_reg  <= (sym_end && fin_reg) ? 32'd0 : phase_work_reg;
                        st_reg     <= T_OUT;
                    end
                end
                T_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        if (stereo_reg && !ch_reg)
                            ch_reg <= 1'b1;
                        else
                            st_reg <= T_IDLE;
                    end
                end
                default: st_reg <= T_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (st_reg == T_IDLE);
    assign m_axis_tvalid = (st_reg == T_OUT);
    assign m_axis_tdata  = {1'b0, smp_reg};
    assign m_axis_tuser  = {4'd0, bad_reg, mend_reg, send_reg, ch_reg};
    assign m_axis_tlast  = !stereo_reg || ch_reg;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input during output");
    a_mend_send: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1]) else $error("msg end");
    a_bad_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tdata == 16'd0) else $error("bad");
`endif
endmodule
`default_nettype wire
